>>> rtl/tdpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpe_pkg: shared definitions for the trial division prime engine
// command codes, result status codes, default sizes and the remainder
// unit status bundle
// ----------------------------------------------------------------------------
package tdpe_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_SPAN_DEF   = 64;
  localparam int CMD_BITS       = 2;
  localparam int STATUS_BITS    = 3;

  // commands
  localparam logic [CMD_BITS-1:0] CMD_CHECK = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RANGE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_LAST  = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_PRIME     = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_PRIME = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NONE      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_SPAN      = 3'd4;

  // remainder unit status, valid for one cycle
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

>>> rtl/tdpe_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpe_rem: bit-serial remainder unit
// shifts the dividend in one bit per cycle and does a restoring subtract,
// reports whether the remainder is zero once it has run through all its shift cycles
// ----------------------------------------------------------------------------
module tdpe_rem
  import tdpe_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output rem_stat_t             stat
);

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   trial;

  assign trial = {rem_r, sh_r[VALUE_BITS-1]};

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_BITS'(VALUE_BITS);
    end else if (cnt_r != '0) begin
      sh_nxt  = {sh_r[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = VALUE_BITS'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[VALUE_BITS-1:0];
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

>>> rtl/trial_division_prime_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_engine: primality by trial division
// each candidate divisor takes one pass of the bit-serial
// remainder unit; a candidate n tries divisors d from 2 up while d * d <= n
// a transaction repeats this for each candidate it tries
// one transaction at a time; busy stays high until its last result is shown
// results are shown for one cycle on out_strobe and cannot be stalled
// synchronous active-low reset returns to idle with no result pending
// ----------------------------------------------------------------------------
module trial_division_prime_engine
  import tdpe_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_SPAN   = MAX_SPAN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_BITS-1:0]    in_cmd,
  input  logic [VALUE_BITS-1:0]  in_first_value,
  input  logic [VALUE_BITS-1:0]  in_last_value,
  // result channel
  output logic                   out_strobe,
  output logic [VALUE_BITS-1:0]  out_value,
  output logic [STATUS_BITS-1:0] out_status,
  output logic                   out_last_of_run
);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,  // waiting for a transaction
    S_TEST   = 6'b000010,  // set up trial division of the candidate
    S_SQ     = 6'b000100,  // divisor squared past candidate, or launch a division
    S_DIV    = 6'b001000,  // waiting for the remainder unit
    S_DECIDE = 6'b010000,  // act on the verdict for the candidate
    S_FLUSH  = 6'b100000   // range done, emit the held prime or none found
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CMD_BITS-1:0]     cmd_r, cmd_nxt;
  logic [VALUE_BITS-1:0]   cand_r, cand_nxt;     // number under test
  logic [VALUE_BITS-1:0]   end_r, end_nxt;       // inclusive range end
  logic [VALUE_BITS-1:0]   div_r, div_nxt;       // trial divisor d
  logic [VALUE_BITS:0]     sq_r, sq_nxt;         // d * d, kept by increments
  logic                    prime_r, prime_nxt;
  logic [VALUE_BITS-1:0]   pend_r, pend_nxt;     // prime held back to learn if final
  logic                    pend_vld_r, pend_vld_nxt;

  logic                    ostb_r, ostb_nxt;
  logic [VALUE_BITS-1:0]   oval_r, oval_nxt;
  logic [STATUS_BITS-1:0]  ost_r, ost_nxt;
  logic                    olast_r, olast_nxt;

  logic                    accept;
  logic                    rem_start;
  logic [VALUE_BITS-1:0]   span;
  rem_stat_t               rem_stat;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign span   = in_last_value - in_first_value;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cand_nxt     = cand_r;
    end_nxt      = end_r;
    div_nxt      = div_r;
    sq_nxt       = sq_r;
    prime_nxt    = prime_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    ostb_nxt     = 1'b0;
    oval_nxt     = oval_r;
    ost_nxt      = ost_r;
    olast_nxt    = olast_r;
    rem_start    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_cmd;
          cand_nxt     = in_first_value;
          end_nxt      = in_last_value;
          pend_vld_nxt = 1'b0;
          case (in_cmd)
            CMD_CHECK: state_nxt = S_TEST;
            CMD_RANGE: begin
              if (in_last_value < in_first_value) begin
                // empty range
                ostb_nxt  = 1'b1;
                oval_nxt  = '0;
                ost_nxt   = ST_NONE;
                olast_nxt = 1'b1;
              end else if (span >= VALUE_BITS'(MAX_SPAN)) begin
                ostb_nxt  = 1'b1;
                oval_nxt  = '0;
                ost_nxt   = ST_SPAN;
                olast_nxt = 1'b1;
              end else begin
                state_nxt = S_TEST;
              end
            end
            CMD_LAST: begin
              if (in_first_value < VALUE_BITS'(2)) begin
                ostb_nxt  = 1'b1;
                oval_nxt  = '0;
                ost_nxt   = ST_NONE;
                olast_nxt = 1'b1;
              end else begin
                state_nxt = S_TEST;
              end
            end
            default: ;  // unknown command is dropped
          endcase
        end
      end

      S_TEST: begin
        div_nxt = VALUE_BITS'(2);
        sq_nxt  = (VALUE_BITS + 1)'(4);
        if (cand_r < VALUE_BITS'(2)) begin
          prime_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SQ;
        end
      end

      S_SQ: begin
        if (sq_r > {1'b0, cand_r}) begin
          // no divisor up to sqrt(n)
          prime_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_DECIDE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {div_r, 1'b1};
            div_nxt   = div_r + 1'b1;
            state_nxt = S_SQ;
          end
        end
      end

      S_DECIDE: begin
        case (cmd_r)
          CMD_CHECK: begin
            ostb_nxt  = 1'b1;
            oval_nxt  = cand_r;
            ost_nxt   = prime_r ? ST_PRIME : ST_NOT_PRIME;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
          CMD_RANGE: begin
            if (prime_r) begin
              // release the previous prime, it is not the final one
              if (pend_vld_r) begin
                ostb_nxt  = 1'b1;
                oval_nxt  = pend_r;
                ost_nxt   = ST_FOUND;
                olast_nxt = 1'b0;
              end
              pend_nxt     = cand_r;
              pend_vld_nxt = 1'b1;
            end
            if (cand_r == end_r) begin
              state_nxt = S_FLUSH;
            end else begin
              cand_nxt  = cand_r + 1'b1;
              state_nxt = S_TEST;
            end
          end
          CMD_LAST: begin
            if (prime_r) begin
              ostb_nxt  = 1'b1;
              oval_nxt  = cand_r;
              ost_nxt   = ST_FOUND;
              olast_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (cand_r <= VALUE_BITS'(2)) begin
              ostb_nxt  = 1'b1;
              oval_nxt  = '0;
              ost_nxt   = ST_NONE;
              olast_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              cand_nxt  = cand_r - 1'b1;
              state_nxt = S_TEST;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_FLUSH: begin
        ostb_nxt  = 1'b1;
        olast_nxt = 1'b1;
        if (pend_vld_r) begin
          oval_nxt = pend_r;
          ost_nxt  = ST_FOUND;
        end else begin
          oval_nxt = '0;
          ost_nxt  = ST_NONE;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      ostb_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      ostb_r     <= ostb_nxt;
    end
    cmd_r   <= cmd_nxt;
    cand_r  <= cand_nxt;
    end_r   <= end_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    prime_r <= prime_nxt;
    pend_r  <= pend_nxt;
    oval_r  <= oval_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  // bit-serial remainder of candidate by trial divisor
  tdpe_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .dividend(cand_r),
    .divisor (div_r),
    .stat    (rem_stat)
  );

  assign out_strobe      = ostb_r;
  assign out_value       = oval_r;
  assign out_status      = ost_r;
  assign out_last_of_run = olast_r;

  // remainder unit only reports while the sequencer waits for it
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> (state_r == S_DIV))
    else $error("remainder result outside of division wait");

  // the final result of a transaction leaves the engine free
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_of_run) |-> !busy)
    else $error("final result shown while still busy");

  // a non-final result is only shown mid-run, with a prime still held back
  a_found_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_run) |-> (busy && pend_vld_r))
    else $error("intermediate result without a held prime");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the trial division prime engine
// drives check, range and greatest-prime commands through the start/busy
// handshake, forecasts every result with an independent trial division
// model and compares each strobed result, field by field, in order
// ----------------------------------------------------------------------------
module tb;
  import tdpe_pkg::*;

  localparam int VB           = VALUE_BITS_DEF;
  localparam int SPAN_LIMIT   = MAX_SPAN_DEF;
  localparam int LIMIT_CYCLES = 10_000_000;
  // quiet time for a stray strobe before the verdict
  localparam int SETTLE_CYCLES = 200;
  localparam int PRINT_CAP     = 100;

  // cmd 3 has no name in the package; the engine must ignore it
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [VB-1:0]          value;
    logic [STATUS_BITS-1:0] status;
    logic                   last;
  } prime_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [CMD_BITS-1:0]    in_cmd = '0;
  logic [VB-1:0]          in_first_value = '0;
  logic [VB-1:0]          in_last_value = '0;
  logic                   out_strobe;
  logic [VB-1:0]          out_value;
  logic [STATUS_BITS-1:0] out_status;
  logic                   out_last_of_run;

  // results forecast at command acceptance, oldest first
  prime_result_t awaited_results[$];
  int            mismatches = 0;
  longint        cycle_count = 0;

  trial_division_prime_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_first_value (in_first_value),
    .in_last_value  (in_last_value),
    .out_strobe     (out_strobe),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: a hung engine or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // primality by trial division, divisors up to the square root
  function automatic bit trial_prime(input longint unsigned n);
    longint unsigned d;
    if (n < 2)
      return 1'b0;
    for (d = 2; d * d <= n; d++)
      if (n % d == 0)
        return 1'b0;
    return 1'b1;
  endfunction

  // queue up every result the engine owes for one accepted transaction
  task automatic forecast_results(input logic [CMD_BITS-1:0] cmd,
                                  input logic [VB-1:0] first_v,
                                  input logic [VB-1:0] last_v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned n;
    longint unsigned primes[$];
    prime_result_t   r;
    lo = first_v;
    hi = last_v;
    r.value = '0;
    r.status = ST_NONE;
    r.last = 1'b1;
    case (cmd)
      CMD_CHECK: begin
        r.value  = first_v;
        r.status = trial_prime(lo) ? ST_PRIME : ST_NOT_PRIME;
        awaited_results.push_back(r);
      end
      CMD_RANGE: begin
        if (hi >= lo && hi - lo + 1 > SPAN_LIMIT) begin
          // span check wins over the primes found in the interval
          r.status = ST_SPAN;
          awaited_results.push_back(r);
        end else begin
          if (hi >= lo)
            for (n = lo; n <= hi; n++)
              if (trial_prime(n))
                primes.push_back(n);
          if (primes.size() == 0) begin
            // reversed interval or no prime in it
            awaited_results.push_back(r);
          end else begin
            foreach (primes[i]) begin
              r.value  = primes[i][VB-1:0];
              r.status = ST_FOUND;
              r.last   = (i == primes.size() - 1);
              awaited_results.push_back(r);
            end
          end
        end
      end
      CMD_LAST: begin
        // search downward; a bound below two finds nothing
        for (n = lo; n >= 2; n--)
          if (trial_prime(n)) begin
            r.value  = n[VB-1:0];
            r.status = ST_FOUND;
            break;
          end
        awaited_results.push_back(r);
      end
      default: ;  // ignored command, nothing owed
    endcase
  endtask

  // result checker: strobe sampled at the edge that ends its cycle
  always @(posedge clk) begin : check_results
    prime_result_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0b",
                                  out_value, out_status, out_last_of_run));
      end else begin
        want = awaited_results.pop_front();
        if (out_value !== want.value)
          report_mismatch($sformatf("value %0d, wanted %0d", out_value, want.value));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d (value %0d)",
                                    out_status, want.status, want.value));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, wanted %0b (value %0d)",
                                    out_last_of_run, want.last, want.value));
      end
    end
  end

  // one transaction: hold start with the fields until an edge sees busy low
  // start is left high; the caller either sends again in this step or gaps
  task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                              input logic [VB-1:0] first_v,
                              input logic [VB-1:0] last_v);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_first_value <= first_v;
    in_last_value  <= last_v;
    do @(posedge clk); while (busy);
    forecast_results(cmd, first_v, last_v);
  endtask

  // random sender gap, each cycle idle with the given percentage
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending until every forecast result has arrived
  // never returns without waiting on a clock edge, so start is assigned once per step
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // check mode: values below two, small primes and composites, wide values
  task automatic test_check_values();
    send_command(CMD_CHECK, 31'd0, 31'd0);
    send_command(CMD_CHECK, 31'd1, 31'h7fff_ffff);
    send_command(CMD_CHECK, 31'd2, 31'd0);
    send_command(CMD_CHECK, 31'd4, 31'd0);
    send_command(CMD_CHECK, 31'd97, 31'd0);
    send_command(CMD_CHECK, 31'd1369, 31'd0);          // 37 squared
    send_command(CMD_CHECK, 31'h7fff_fffe, 31'd0);     // wide even value
    send_command(CMD_CHECK, 31'h7fff_fffd, 31'd0);     // multiple of five
    drain_results();
  endtask

  // range mode: empty, single prime, full span, span overflow, reversed
  task automatic test_range_values();
    send_command(CMD_RANGE, 31'd0, 31'd1);             // nothing below two
    send_command(CMD_RANGE, 31'd2, 31'd2);
    send_command(CMD_RANGE, 31'd24, 31'd28);           // prime gap, none found
    send_command(CMD_RANGE, 31'd0, 31'd63);            // exactly the span limit
    send_command(CMD_RANGE, 31'd0, 31'd64);            // one past the limit
    send_command(CMD_RANGE, 31'd20, 31'd10);           // reversed interval
    send_command(CMD_RANGE, 31'd0, 31'h7fff_ffff);     // widest span
    send_command(CMD_RANGE, 31'h7fff_ffff, 31'd0);     // widest reversal
    send_command(CMD_RANGE, 31'd1000, 31'd1063);
    drain_results();
  endtask

  // greatest prime at or below: bounds below two, primes, a wide search
  task automatic test_last_values();
    send_command(CMD_LAST, 31'd0, 31'h7fff_ffff);
    send_command(CMD_LAST, 31'd1, 31'd0);
    send_command(CMD_LAST, 31'd2, 31'd0);
    send_command(CMD_LAST, 31'd100, 31'd0);
    send_command(CMD_LAST, 31'd1 << 20, 31'd0);
    drain_results();
  endtask

  // unused command code must produce nothing; a check follows to prove life
  task automatic test_ignored_command();
    send_command(CMD_UNUSED, 31'h7fff_ffff, 31'h7fff_ffff);
    send_command(CMD_UNUSED, 31'd0, 31'd0);
    send_command(CMD_CHECK, 31'd7919, 31'd0);
    drain_results();
  endtask

  // random mix, ranges mostly well-formed and small; ignored commands not counted
  task automatic test_random_traffic(input int count, input int idle_pct);
    int                  sent;
    int                  pick;
    int unsigned         f;
    logic [CMD_BITS-1:0] cmd;
    logic [VB-1:0]       a;
    logic [VB-1:0]       b;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      b = VB'($urandom);
      if (pick < 30) begin
        cmd = CMD_CHECK;
        if ($urandom_range(7) == 0) begin
          // wide value with a small factor keeps the divisor search short
          f = $urandom_range(13, 2);
          a = VB'(($urandom_range(32'h7fff_ffff) / f) * f);
        end else begin
          a = VB'($urandom_range(4095));
        end
      end else if (pick < 75) begin
        cmd = CMD_RANGE;
        case ($urandom_range(9))
          0: begin
            // span overflow with wide values
            a = VB'($urandom_range(32'h4000_0000));
            b = a + VB'($urandom_range(32'h3fff_ffff, SPAN_LIMIT));
          end
          1: begin
            // reversed interval
            a = VB'($urandom_range(32'h7fff_ffff, 1));
            b = VB'($urandom_range(a - 1));
          end
          2: begin
            a = VB'($urandom_range(8));
            b = VB'($urandom_range(8));
          end
          default: begin
            a = VB'($urandom_range(2047));
            b = a + VB'($urandom_range(SPAN_LIMIT - 1));
          end
        endcase
      end else if (pick < 95) begin
        cmd = CMD_LAST;
        if ($urandom_range(15) == 0)
          a = VB'($urandom_range(32'd1 << 20));
        else
          a = VB'($urandom_range(20000));
      end else begin
        cmd = CMD_UNUSED;
        a = VB'($urandom);
      end
      if (cmd != CMD_UNUSED)
        sent++;
      send_command(cmd, a, b);
      sender_gap(idle_pct);
      // occasional full stop until the engine has caught up
      if ($urandom_range(19) == 0)
        drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_check_values();
    test_range_values();
    test_last_values();
    test_ignored_command();
    // no idling, then heavy sender gaps, then light sender gaps
    test_random_traffic(25, 0);
    test_random_traffic(25, 57);
    test_random_traffic(25, 28);

    start <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
    // let any stray strobe show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
